[design/qrs_pkg.sv]
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared constants, types and the root clamp for the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COEF_W    = 32;

    // square root of the discriminant quarter: 64-bit radicand, 32-bit root
    localparam int RAD_W     = 2 * COEF_W;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int SQ_STAGES = ROOT_W;
    localparam int SQ_REM_W  = ROOT_W + 2;

    // -B +/- S is below 2^34 in magnitude
    localparam int SUM_W     = COEF_W + 3;
    localparam int MAG_W     = SUM_W - 1;
    localparam int NUM_W     = MAG_W + FRAC_BITS + 1;
    localparam int DIV_W     = COEF_W + 1;
    localparam int QUO_W     = COEF_W + 1;

    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    localparam logic [QUO_W-1:0]  MAX_POS_Q = QUO_W'((64'd1 << (COEF_W - 1)) - 64'd1);
    localparam logic [QUO_W-1:0]  MAX_NEG_Q = QUO_W'(64'd1 << (COEF_W - 1));
    localparam logic [COEF_W-1:0] ROOT_MAX  = COEF_W'(MAX_POS_Q);
    localparam logic [COEF_W-1:0] ROOT_MIN  = COEF_W'(MAX_NEG_Q);

    typedef enum logic [1:0] {
        ST_TWO    = 2'd0,
        ST_DOUBLE = 2'd1,
        ST_NONE   = 2'd2,
        ST_AZERO  = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
    } coef_t;

    typedef struct packed {
        coef_t coef;
        logic  a_zero;
    } fe_item_t;

    typedef struct packed {
        logic a_zero;
        logic no_real;
        logic dbl;
    } meta_t;

    typedef struct packed {
        meta_t                    meta;
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic [1:0]               r;
    } sq_tag_t;

    typedef struct packed {
        meta_t meta;
        logic  neg;
    } dv_tag_t;

    typedef struct packed {
        logic [COEF_W-1:0] root;
        logic              sat;
    } root_res_t;

    // apply sign and clamp a rounded quotient magnitude to the Q format range
    function automatic root_res_t clamp_root(logic [QUO_W-1:0] q, logic over, logic neg);
        root_res_t res;
        res.sat = 1'b0;
        if (neg)
        begin
            if (over || q > MAX_NEG_Q)
            begin
                res.root = ROOT_MIN;
                res.sat  = 1'b1;
            end
            else
            begin
                res.root = COEF_W'(0) - q[COEF_W-1:0];
            end
        end
        else
        begin
            if (over || q > MAX_POS_Q)
            begin
                res.root = ROOT_MAX;
                res.sat  = 1'b1;
            end
            else
            begin
                res.root = q[COEF_W-1:0];
            end
        end
        return res;
    endfunction

endpackage

[design/qrs_front.sv]
// ----------------------------------------------------------------------------
// qrs_front
// Request capture: latches coefficients, flags a zero leading term.
// ----------------------------------------------------------------------------
module qrs_front
    import qrs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [COEF_W-1:0] coef_a,
    input  logic signed [COEF_W-1:0] coef_b,
    input  logic signed [COEF_W-1:0] coef_c,
    output logic                     out_valid,
    output fe_item_t                 out_item,
    input  logic                     out_ready
);

    fe_item_t item_reg;
    logic     valid_reg;
    logic     take;

    assign busy      = valid_reg && !out_ready;
    assign take      = start && !busy;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.coef.a <= coef_a;
            item_reg.coef.b <= coef_b;
            item_reg.coef.c <= coef_c;
            item_reg.a_zero <= (coef_a == '0);
        end
    end

endmodule

[design/qrs_fifo.sv]
// ----------------------------------------------------------------------------
// qrs_fifo
// Short request queue between the front and the arithmetic pipeline.
// ----------------------------------------------------------------------------
module qrs_fifo
    import qrs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  fe_item_t wr_data,
    output logic     full,
    input  logic     pop,
    output logic     empty,
    output fe_item_t rd_data
);

    fe_item_t         mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == (PTR_W+1)'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (PTR_W+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (PTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[design/qrs_sqrt.sv]
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined integer square root, one root bit per stage, with remainder.
// ----------------------------------------------------------------------------
module qrs_sqrt
    import qrs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [RAD_W-1:0]    radicand,
    input  sq_tag_t             in_tag,
    output logic                out_valid,
    output logic [ROOT_W-1:0]   root,
    output logic [SQ_REM_W-1:0] rem,
    output sq_tag_t             out_tag
);

    logic                valid_s [SQ_STAGES+1];
    logic [RAD_W-1:0]    rad_s   [SQ_STAGES+1];
    logic [SQ_REM_W-1:0] rem_s   [SQ_STAGES+1];
    logic [ROOT_W-1:0]   root_s  [SQ_STAGES+1];
    sq_tag_t             tag_s   [SQ_STAGES+1];

    assign valid_s[0] = in_valid;
    assign rad_s[0]   = radicand;
    assign rem_s[0]   = '0;
    assign root_s[0]  = '0;
    assign tag_s[0]   = in_tag;

    for (genvar k = 0; k < SQ_STAGES; k++)
    begin : g_stage
        logic [SQ_REM_W-1:0] rem_sh;
        logic [SQ_REM_W-1:0] trial;
        logic                fit;

        always_comb
        begin
            // bring down the next two radicand bits
            rem_sh = {rem_s[k][SQ_REM_W-3:0], rad_s[k][RAD_W-1 -: 2]};
            trial  = {root_s[k], 2'b01};
            fit    = (rem_sh >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_s[k+1] <= 1'b0;
            end
            else
            begin
                valid_s[k+1] <= valid_s[k];
            end
        end

        always_ff @(posedge clk)
        begin
            rad_s[k+1]  <= rad_s[k] << 2;
            rem_s[k+1]  <= fit ? (rem_sh - trial) : rem_sh;
            root_s[k+1] <= {root_s[k][ROOT_W-2:0], fit};
            tag_s[k+1]  <= tag_s[k];
        end
    end

    assign out_valid = valid_s[SQ_STAGES];
    assign root      = root_s[SQ_STAGES];
    assign rem       = rem_s[SQ_STAGES];
    assign out_tag   = tag_s[SQ_STAGES];

endmodule

[design/qrs_div.sv]
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
module qrs_div
    import qrs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [DIV_W-1:0] den,
    input  dv_tag_t          in_tag,
    output logic             out_valid,
    output logic [QUO_W-1:0] quo,
    output logic             over,
    output dv_tag_t          out_tag
);

    localparam int WIDE_W = NUM_W + DIV_W;

    logic             valid_s [QUO_W+1];
    logic [NUM_W-1:0] rem_s   [QUO_W+1];
    logic [DIV_W-1:0] den_s   [QUO_W+1];
    logic [QUO_W-1:0] quo_s   [QUO_W+1];
    logic             over_s  [QUO_W+1];
    dv_tag_t          tag_s   [QUO_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_s[0] <= 1'b0;
        end
        else
        begin
            valid_s[0] <= in_valid;
        end
    end

    // quotient wider than QUO_W bits: flag it and let the clamp take over
    always_ff @(posedge clk)
    begin
        rem_s[0]  <= num;
        den_s[0]  <= den;
        quo_s[0]  <= '0;
        over_s[0] <= ((num >> QUO_W) >= NUM_W'(den));
        tag_s[0]  <= in_tag;
    end

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_stage
        localparam int SH = QUO_W - 1 - k;

        logic [WIDE_W-1:0] rem_x;
        logic [WIDE_W-1:0] den_x;
        logic [WIDE_W-1:0] diff;
        logic              fit;

        always_comb
        begin
            rem_x = WIDE_W'(rem_s[k]);
            den_x = WIDE_W'(den_s[k]) << SH;
            diff  = rem_x - den_x;
            fit   = (rem_x >= den_x);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_s[k+1] <= 1'b0;
            end
            else
            begin
                valid_s[k+1] <= valid_s[k];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_s[k+1]  <= fit ? diff[NUM_W-1:0] : rem_s[k];
            den_s[k+1]  <= den_s[k];
            quo_s[k+1]  <= {quo_s[k][QUO_W-2:0], fit};
            over_s[k+1] <= over_s[k];
            tag_s[k+1]  <= tag_s[k];
        end
    end

    assign out_valid = valid_s[QUO_W];
    assign quo       = quo_s[QUO_W];
    assign over      = over_s[QUO_W];
    assign out_tag   = tag_s[QUO_W];

endmodule

[design/quadratic_root_solver.sv]
// ----------------------------------------------------------------------------
// quadratic_root_solver
// done pulses once for each request taken (start high, busy low).
// Throughput: one request per cycle; busy rises only if the request queue fills.
// Depth is set by the 32-stage square root and the two dividers.
// Reset clears all valid flags and the queue; data registers are not reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module quadratic_root_solver
    import qrs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [COEF_W-1:0] coef_a,
    input  logic signed [COEF_W-1:0] coef_b,
    input  logic signed [COEF_W-1:0] coef_c,
    output logic                     done,
    output logic signed [COEF_W-1:0] root_plus,
    output logic signed [COEF_W-1:0] root_minus,
    output logic [1:0]               status,
    output logic                     saturated
);

    logic     fe_valid;
    fe_item_t fe_item;
    logic     q_full;
    logic     q_empty;
    fe_item_t q_item;
    logic     pop;

    qrs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .coef_a    (coef_a),
        .coef_b    (coef_b),
        .coef_c    (coef_c),
        .out_valid (fe_valid),
        .out_item  (fe_item),
        .out_ready (!q_full)
    );

    qrs_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (fe_valid),
        .wr_data (fe_item),
        .full    (q_full),
        .pop     (pop),
        .empty   (q_empty),
        .rd_data (q_item)
    );

    // the pipeline never stalls: drain the queue whenever it holds a request
    assign pop = !q_empty;

    // products B*B and A*C
    logic                     v1_reg;
    logic signed [RAD_W-1:0]  bb_reg;
    logic signed [RAD_W-1:0]  ac_reg;
    logic signed [COEF_W-1:0] a1_reg;
    logic signed [COEF_W-1:0] b1_reg;
    logic                     az1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= pop;
        end
    end

    always_ff @(posedge clk)
    begin
        bb_reg  <= q_item.coef.b * q_item.coef.b;
        ac_reg  <= q_item.coef.a * q_item.coef.c;
        a1_reg  <= q_item.coef.a;
        b1_reg  <= q_item.coef.b;
        az1_reg <= q_item.a_zero;
    end

    // discriminant as 4*e + r with e = B*B/4 - A*C
    logic signed [RAD_W-1:0] e_next;
    logic                    v2_reg;
    logic [RAD_W-1:0]        ue_reg;
    sq_tag_t                 tag2_reg;

    assign e_next = $signed({2'b00, bb_reg[RAD_W-1:2]}) - ac_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ue_reg                 <= e_next[RAD_W-1] ? '0 : e_next;
        tag2_reg.meta.a_zero   <= az1_reg;
        tag2_reg.meta.no_real  <= e_next[RAD_W-1];
        tag2_reg.meta.dbl      <= (e_next == '0) && (bb_reg[1:0] == 2'b00);
        tag2_reg.a             <= a1_reg;
        tag2_reg.b             <= b1_reg;
        tag2_reg.r             <= bb_reg[1:0];
    end

    logic                sq_valid;
    logic [ROOT_W-1:0]   sq_root;
    logic [SQ_REM_W-1:0] sq_rem;
    sq_tag_t             sq_tag;

    qrs_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2_reg),
        .radicand  (ue_reg),
        .in_tag    (tag2_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .rem       (sq_rem),
        .out_tag   (sq_tag)
    );

    // S = floor(sqrt(4e + r)) = 2*s0 or 2*s0 + 1; rem is e - s0*s0
    logic                    inc;
    logic [SUM_W-1:0]        s_ext;
    logic signed [SUM_W-1:0] nb_ext;
    logic                    v3_reg;
    logic signed [SUM_W-1:0] nump_reg;
    logic signed [SUM_W-1:0] numm_reg;
    logic signed [COEF_W-1:0] a3_reg;
    meta_t                   meta3_reg;

    always_comb
    begin
        inc = ((sq_tag.r == 2'd1) && (SQ_REM_W'(sq_root) <= sq_rem))
           || ((sq_tag.r == 2'd0) && (SQ_REM_W'(sq_root) < sq_rem));
        s_ext  = SUM_W'({sq_root, 1'b0}) + SUM_W'(inc);
        nb_ext = SUM_W'(0) - SUM_W'(sq_tag.b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        nump_reg  <= nb_ext + $signed(s_ext);
        numm_reg  <= nb_ext - $signed(s_ext);
        a3_reg    <= sq_tag.a;
        meta3_reg <= sq_tag.meta;
    end

    // dividend |num| * 2^FRAC_BITS + |A| over 2|A| rounds to nearest
    logic [MAG_W-1:0]  magp;
    logic [MAG_W-1:0]  magm;
    logic [COEF_W-1:0] maga;
    logic              v4_reg;
    logic [NUM_W-1:0]  divp_reg;
    logic [NUM_W-1:0]  divm_reg;
    logic [DIV_W-1:0]  den_reg;
    dv_tag_t           tagp_reg;
    dv_tag_t           tagm_reg;

    always_comb
    begin
        magp = nump_reg[SUM_W-1] ? MAG_W'(SUM_W'(0) - nump_reg) : MAG_W'(nump_reg);
        magm = numm_reg[SUM_W-1] ? MAG_W'(SUM_W'(0) - numm_reg) : MAG_W'(numm_reg);
        maga = a3_reg[COEF_W-1] ? (COEF_W'(0) - a3_reg) : a3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        divp_reg      <= (NUM_W'(magp) << FRAC_BITS) + NUM_W'(maga);
        divm_reg      <= (NUM_W'(magm) << FRAC_BITS) + NUM_W'(maga);
        den_reg       <= {maga, 1'b0};
        tagp_reg.meta <= meta3_reg;
        tagp_reg.neg  <= nump_reg[SUM_W-1] ^ a3_reg[COEF_W-1];
        tagm_reg.meta <= meta3_reg;
        tagm_reg.neg  <= numm_reg[SUM_W-1] ^ a3_reg[COEF_W-1];
    end

    logic             dp_valid;
    logic [QUO_W-1:0] dp_quo;
    logic             dp_over;
    dv_tag_t          dp_tag;
    logic             dm_valid;
    logic [QUO_W-1:0] dm_quo;
    logic             dm_over;
    dv_tag_t          dm_tag;

    qrs_div u_div_plus (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .num       (divp_reg),
        .den       (den_reg),
        .in_tag    (tagp_reg),
        .out_valid (dp_valid),
        .quo       (dp_quo),
        .over      (dp_over),
        .out_tag   (dp_tag)
    );

    qrs_div u_div_minus (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .num       (divm_reg),
        .den       (den_reg),
        .in_tag    (tagm_reg),
        .out_valid (dm_valid),
        .quo       (dm_quo),
        .over      (dm_over),
        .out_tag   (dm_tag)
    );

    // clamp, then override for the degenerate cases
    root_res_t rp;
    root_res_t rm;
    logic [COEF_W-1:0] rootp_next;
    logic [COEF_W-1:0] rootm_next;
    status_t           status_next;
    logic              sat_next;
    logic              done_reg;
    logic [COEF_W-1:0] rootp_reg;
    logic [COEF_W-1:0] rootm_reg;
    status_t           status_reg;
    logic              sat_reg;

    always_comb
    begin
        rp          = clamp_root(dp_quo, dp_over, dp_tag.neg);
        rm          = clamp_root(dm_quo, dm_over, dm_tag.neg);
        rootp_next  = rp.root;
        rootm_next  = rm.root;
        sat_next    = rp.sat || rm.sat;
        status_next = dp_tag.meta.dbl ? ST_DOUBLE : ST_TWO;
        if (dp_tag.meta.a_zero || dp_tag.meta.no_real)
        begin
            rootp_next  = '0;
            rootm_next  = '0;
            sat_next    = 1'b0;
            status_next = dp_tag.meta.a_zero ? ST_AZERO : ST_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dp_valid && dm_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rootp_reg  <= rootp_next;
        rootm_reg  <= rootm_next;
        status_reg <= status_next;
        sat_reg    <= sat_next;
    end

    assign done       = done_reg;
    assign root_plus  = rootp_reg;
    assign root_minus = rootm_reg;
    assign status     = status_reg;
    assign saturated  = sat_reg;

endmodule

[tb/sv/tb_quadratic_root_solver.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quadratic_root_solver
// Drives coefficient requests into the quadratic root solver and checks every
// result against an exact integer prediction of the roots, status and clamp.
// ----------------------------------------------------------------------------
module tb_quadratic_root_solver;
    import qrs_pkg::*;

    typedef struct {
        logic [31:0] root_p;
        logic [31:0] root_m;
        status_t     st;
        logic        sat;
    } roots_t;

    // round num * 2^FRAC_BITS / (2a) to nearest, ties away, then clamp
    function automatic logic [31:0] scaled_root(longint num, longint a, ref logic sat);
        logic        neg;
        logic [63:0] mn;
        logic [63:0] ma;
        logic [63:0] q;
        neg = (num < 0) != (a < 0);
        mn  = (num < 0) ? 64'(-num) : 64'(num);
        ma  = (a < 0) ? 64'(-a) : 64'(a);
        q   = ((mn << FRAC_BITS) + ma) / (2 * ma);
        if (q == 0)
            return 32'd0;
        if (neg)
        begin
            if (q > 64'h8000_0000)
            begin
                sat = 1'b1;
                q   = 64'h8000_0000;
            end
            return 32'd0 - q[31:0];
        end
        if (q > 64'h7FFF_FFFF)
        begin
            sat = 1'b1;
            q   = 64'h7FFF_FFFF;
        end
        return q[31:0];
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bt;
        res = 0;
        bt  = 64'd1 << 62;
        while (bt > v)
            bt >>= 2;
        while (bt != 0)
        begin
            if (v >= res + bt)
            begin
                v   = v - (res + bt);
                res = (res >> 1) + bt;
            end
            else
                res >>= 1;
            bt >>= 2;
        end
        return res;
    endfunction

    function automatic roots_t solve_quadratic(logic [31:0] ca, logic [31:0] cb,
                                               logic [31:0] cc);
        roots_t          r;
        longint          a;
        longint          b;
        longint          c;
        longint unsigned h;
        longint          e;
        longint unsigned s0;
        longint unsigned tq;
        longint unsigned s;
        logic [1:0]      rem;
        logic            sat;
        a = longint'($signed(ca));
        b = longint'($signed(cb));
        c = longint'($signed(cc));
        r.root_p = '0;
        r.root_m = '0;
        r.sat    = 1'b0;
        sat      = 1'b0;
        if (a == 0)
        begin
            r.st = ST_AZERO;
            return r;
        end
        h   = b * b;
        rem = h[1:0];
        e   = longint'(h >> 2) - a * c;
        if (e < 0)
        begin
            r.st = ST_NONE;
            return r;
        end
        s0 = floor_sqrt(e);
        tq = s0 * s0 + s0;
        s  = 2 * s0;
        if ((rem == 1 && tq <= e) || (rem == 0 && tq < e))
            s = s + 1;
        r.st     = (e == 0 && rem == 0) ? ST_DOUBLE : ST_TWO;
        r.root_p = scaled_root(-b + longint'(s), a, sat);
        r.root_m = scaled_root(-b - longint'(s), a, sat);
        r.sat    = sat;
        return r;
    endfunction

    class root_scoreboard;
        roots_t pending_roots[$];
        int     mismatches;
        int     checked;

        function void note_request(logic [31:0] ca, logic [31:0] cb, logic [31:0] cc);
            pending_roots.push_back(solve_quadratic(ca, cb, cc));
        endfunction

        function void check_result(logic [31:0] rp, logic [31:0] rm, logic [1:0] st,
                                   logic sat);
            roots_t x;
            if (pending_roots.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result rp=%h rm=%h st=%0d", rp, rm, st);
                return;
            end
            x = pending_roots.pop_front();
            checked++;
            if (rp !== x.root_p || rm !== x.root_m || st !== x.st || sat !== x.sat)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result %0d: exp rp=%h rm=%h st=%0d sat=%b,",
                              " got rp=%h rm=%h st=%0d sat=%b"},
                             checked, x.root_p, x.root_m, x.st, x.sat, rp, rm, st, sat);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] coef_a;
    logic [31:0] coef_b;
    logic [31:0] coef_c;
    logic        done;
    logic [31:0] root_plus;
    logic [31:0] root_minus;
    logic [1:0]  status;
    logic        saturated;

    root_scoreboard sb;
    int             idle_cycles;
    int             sent;
    bit             no_gaps;

    quadratic_root_solver u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .coef_a     (coef_a),
        .coef_b     (coef_b),
        .coef_c     (coef_c),
        .done       (done),
        .root_plus  (root_plus),
        .root_minus (root_minus),
        .status     (status),
        .saturated  (saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // one request, called at an edge: optional gap, then hold start until
    // busy is low at an edge; start stays high so requests can follow back to back
    task automatic send_request(logic [31:0] ca, logic [31:0] cb, logic [31:0] cc);
        while (!no_gaps && $urandom_range(99) < 19)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start  <= 1'b1;
        coef_a <= ca;
        coef_b <= cb;
        coef_c <= cc;
        do
            @(posedge clk);
        while (busy);
        sb.note_request(ca, cb, cc);
        sent++;
    endtask

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(8191)) - 4096) << 16;
            2: return 32'($signed($urandom_range(65535)) - 32768) << 8;
            3: return 32'($signed($urandom_range(255)) - 128);
            4: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF} ^ $urandom_range(3);
            default: return 32'($signed($urandom_range(2047)) - 1024) << 12;
        endcase
    endfunction

    // a double root with random content: b = 2ak, c = a*k*k in raw units
    task automatic send_double();
        int          ka;
        int          kk;
        longint      bb;
        longint      cc;
        ka = $signed($urandom_range(2047)) - 1024;
        kk = $signed($urandom_range(2047)) - 1024;
        if (ka == 0)
            ka = 1;
        bb = 2 * longint'(ka) * kk;
        cc = longint'(ka) * kk * kk;
        send_request(32'(ka), 32'(bb), 32'(cc));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(root_plus, root_minus, status, saturated);
    end

    // cycles with no request and no result taken
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000)
        begin
            $display("watchdog expired with %0d results pending", sb.pending_roots.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        sb          = new();
        sent        = 0;
        no_gaps     = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        coef_a      = '0;
        coef_b      = '0;
        coef_c      = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: zero a, extremes, sign mixes, no roots, double roots, clamps
        send_request(32'd0, 32'h0001_0000, 32'h0002_0000);
        send_request(32'd0, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(32'h0001_0000, 32'hFFFD_0000, 32'h0002_0000);
        send_request(32'h0001_0000, 32'd0, 32'h0001_0000);
        send_request(32'h0001_0000, 32'hFFFE_0000, 32'h0001_0000);
        send_request(32'h0001_0000, 32'd0, 32'd0);
        send_request(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_request(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(32'd1, 32'h7FFF_FFFF, 32'd0);
        send_request(32'd1, 32'h8000_0000, 32'h8000_0000);
        send_request(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_request(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        send_request(32'h0002_0000, 32'd1, 32'd0);
        send_request(32'h0002_0000, 32'd3, 32'd1);
        send_request(32'hFFFE_0000, 32'h0004_0000, 32'hFFFE_0000);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'd1, 32'd1, 32'd0);

        for (int i = 0; i < 830; i++)
        begin
            no_gaps = (i >= 300 && i < 450);
            if ($urandom_range(3) == 0)
                send_double();
            else
                send_request(rand_coef(), rand_coef(), rand_coef());
        end
        start <= 1'b0;

        while (sb.pending_roots.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        $display("%0d requests sent, %0d results checked", sent, sb.checked);
        $display("covered zero a, negative, double and clamped roots, gaps and back to back");
        if (sb.mismatches == 0 && sb.pending_roots.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
